// File: src/ipv4_interface_address_classifier_unit_assert.svh
// Assertion macros for the IPv4 interface address classifier
`ifndef IPV4_INTERFACE_ADDRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define IPV4_INTERFACE_ADDRESS_CLASSIFIER_UNIT_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define IAC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define IAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ipv4iac_pkg.sv
// Shared types, constants and helpers for the IPv4 interface address classifier
package ipv4iac_pkg;

  // table size default
  localparam int DEF_ENTRIES = 8;

  // address constants
  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
  localparam logic [31:0] CLASS_A_MASK = 32'hff00_0000;
  localparam logic [31:0] CLASS_B_MASK = 32'hffff_0000;
  localparam logic [31:0] CLASS_C_MASK = 32'hffff_ff00;
  localparam logic [31:0] LOOPBACK_NET = 32'h7f00_0000;
  localparam logic [2:0]  CLASS_DE_TOP = 3'b111;

  // item modes
  localparam logic [1:0] MODE_PROGRAM  = 2'd0;
  localparam logic [1:0] MODE_DELETE   = 2'd1;
  localparam logic [1:0] MODE_CLASSIFY = 2'd2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_WORD_W = CFG_ADDR_W - 2;
  localparam logic [CFG_WORD_W-1:0] REG_NET_LOCALITY = 1'd0;
  localparam logic NET_LOCALITY_RST = 1'b1;

  // input transaction
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  entry_index;
    logic [31:0] address;
    logic [31:0] subnet_mask;
    logic [3:0]  interface_id;
    logic        iface_broadcast;
  } in_data_t;

  // result transaction
  typedef struct packed {
    logic is_local;
    logic is_broadcast;
    logic can_forward;
  } out_data_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic        slot_ok;
    logic [2:0]  slot;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [31:0] subnetmask;
    logic [3:0]  iface;
    logic        bcast_en;
    logic        bcast_fixed;
    logic        can_forward;
  } cmd_t;

  // one table entry
  typedef struct packed {
    logic [3:0]  iface;
    logic [31:0] net;
    logic [31:0] netmask;
    logic [31:0] subnet;
    logic [31:0] subnetmask;
    logic [31:0] bcast;
    logic [31:0] netbcast;
  } entry_t;

  // queue occupancy
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } queue_stat_t;

  // classful mask from the leading address bits
  function automatic logic [31:0] classful_mask(input logic [31:0] addr);
    logic [31:0] mask;
    if (!addr[31]) begin
      mask = CLASS_A_MASK;
    end else if (!addr[30]) begin
      mask = CLASS_B_MASK;
    end else begin
      mask = CLASS_C_MASK;
    end
    return mask;
  endfunction

endpackage

// File: src/ipv4_interface_address_classifier_unit.sv
// Top level of the IPv4 interface address classifier
//
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_ready       ipv4iac_pkg::in_data_t
// out_      output     out_valid / out_ready     ipv4iac_pkg::out_data_t
// cfg_      input      APB psel/penable/pready   net locality select at word 0
//
// Program, delete and unused-mode items are answered from the back-end idle state.
// A classify item is popped and then walks the table in the back end: one cycle per
// table entry through the single registered read port, then a drain step and
// the step that loads the result register.
// The front end and a two-deep command queue accept transactions until the queue is full
// while the back end walks the table or a result waits on out_ready.
// Reset (rst_n low, synchronous) clears all entry valid bits and the queue;
// the locality select resets to 1. No clearing pass is needed.
`include "ipv4_interface_address_classifier_unit_assert.svh"

module ipv4_interface_address_classifier_unit #(
  parameter int ENTRIES = ipv4iac_pkg::DEF_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ipv4iac_pkg::in_data_t              in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ipv4iac_pkg::out_data_t             out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ipv4iac_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ipv4iac_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ipv4iac_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CA  = ipv4iac_pkg::CFG_ADDR_W;
  localparam int QCW = ipv4iac_pkg::QCNT_W;
  localparam logic [QCW-1:0] Q_DEPTH = QCW'(ipv4iac_pkg::QUEUE_DEPTH);

  logic                     net_loc_r;
  logic                     cfg_wr;
  logic                     cfg_hit;
  logic                     in_acc;
  logic                     push_valid, push_ready;
  logic                     pop_valid, pop_ready;
  ipv4iac_pkg::cmd_t        push_cmd, pop_cmd;
  ipv4iac_pkg::queue_stat_t q_stat;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CA-1:2] == ipv4iac_pkg::REG_NET_LOCALITY);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? {{(ipv4iac_pkg::CFG_DATA_W-1){1'b0}}, net_loc_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_loc_r <= ipv4iac_pkg::NET_LOCALITY_RST;
    end else if (cfg_wr && cfg_hit) begin
      net_loc_r <= cfg_pwdata[0];
    end
  end

  ipv4iac_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  ipv4iac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .stat      (q_stat)
  );

  ipv4iac_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .net_locality(net_loc_r),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_cmd     (pop_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // checks
  assign in_acc = in_valid && in_ready;

  `IAC_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= Q_DEPTH, "queue count over depth")
  `IAC_ASSERT_SAME(a_empty_accepts, q_stat.empty, in_ready, "empty queue refuses a transaction")
  `IAC_ASSERT_NEXT(a_accept_lands, in_acc && !pop_valid, pop_valid, "accepted transaction lost")
  `IAC_ASSERT_NEXT(a_cfg_write, cfg_wr && cfg_hit, net_loc_r == $past(cfg_pwdata[0]), "write lost")

endmodule

// File: src/ipv4iac_front.sv
// Front end: decodes input transactions into queue commands
module ipv4iac_front #(
  parameter int ENTRIES = ipv4iac_pkg::DEF_ENTRIES
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipv4iac_pkg::in_data_t in_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output ipv4iac_pkg::cmd_t     push_cmd
);

  logic [31:0] cls_mask;
  logic [31:0] addr;
  logic        sm_zero;
  logic        class_a;

  // handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  assign addr     = in_data.address;
  assign cls_mask = ipv4iac_pkg::classful_mask(addr);
  assign sm_zero  = (in_data.subnet_mask == 32'd0);
  assign class_a  = !addr[31];

  // masks, slot range check and address-only answers
  always_comb begin
    push_cmd.op          = in_data.mode;
    push_cmd.slot_ok     = ({29'd0, in_data.entry_index} < 32'(ENTRIES));
    push_cmd.slot        = in_data.entry_index;
    push_cmd.address     = addr;
    push_cmd.netmask     = sm_zero ? cls_mask : (cls_mask & in_data.subnet_mask);
    push_cmd.subnetmask  = sm_zero ? cls_mask : in_data.subnet_mask;
    push_cmd.iface       = in_data.interface_id;
    push_cmd.bcast_en    = in_data.iface_broadcast;
    push_cmd.bcast_fixed = (addr == ipv4iac_pkg::ALL_ONES) || (addr == 32'd0);
    push_cmd.can_forward = 1'b1;
    // class D/E, net 0 and loopback are not forwarded
    if (addr[31:29] == ipv4iac_pkg::CLASS_DE_TOP) begin
      push_cmd.can_forward = 1'b0;
    end else if (class_a && (((addr & ipv4iac_pkg::CLASS_A_MASK) == 32'd0) ||
                             ((addr & ipv4iac_pkg::CLASS_A_MASK) ==
                              ipv4iac_pkg::LOOPBACK_NET))) begin
      push_cmd.can_forward = 1'b0;
    end
  end

endmodule

// File: src/ipv4iac_queue.sv
// Short command queue decoupling front end and back end
module ipv4iac_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  output logic                     push_ready,
  input  ipv4iac_pkg::cmd_t        push_cmd,
  output logic                     pop_valid,
  input  logic                     pop_ready,
  output ipv4iac_pkg::cmd_t        pop_cmd,
  output ipv4iac_pkg::queue_stat_t stat
);

  localparam int QW = ipv4iac_pkg::QPTR_W;
  localparam int CW = ipv4iac_pkg::QCNT_W;

  ipv4iac_pkg::cmd_t slots_r [ipv4iac_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(ipv4iac_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  assign stat.count = count_r;
  assign stat.empty = !pop_valid;
  assign stat.full  = !push_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/ipv4iac_back.sv
// Back end: table updates and entry walk for classify commands
module ipv4iac_back #(
  parameter int ENTRIES = ipv4iac_pkg::DEF_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   net_locality,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  ipv4iac_pkg::cmd_t      pop_cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ipv4iac_pkg::out_data_t out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // entry table
  ipv4iac_pkg::entry_t mem [ENTRIES];
  ipv4iac_pkg::entry_t rd_entry_r;
  ipv4iac_pkg::entry_t mem_wdata;
  logic                mem_we;
  logic [IDX_W-1:0]    waddr;
  logic [IDX_W+2:0]    slot_ext;

  logic [1:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  ipv4iac_pkg::cmd_t      cur_r, cur_nxt;
  logic                   hit_local_r, hit_local_nxt;
  logic                   hit_bcast_r, hit_bcast_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ipv4iac_pkg::out_data_t out_data_r, out_data_nxt;
  logic [ENTRIES-1:0]     entry_valid_r, entry_valid_nxt;

  logic out_free;
  logic local_m;
  logic bcast_m;
  logic [31:0] a;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign slot_ext = {{IDX_W{1'b0}}, pop_cmd.slot};
  assign waddr    = slot_ext[IDX_W-1:0];

  // derived entry fields on program
  always_comb begin
    mem_wdata.iface      = pop_cmd.iface;
    mem_wdata.netmask    = pop_cmd.netmask;
    mem_wdata.subnetmask = pop_cmd.subnetmask;
    mem_wdata.net        = pop_cmd.address & pop_cmd.netmask;
    mem_wdata.subnet     = pop_cmd.address & pop_cmd.subnetmask;
    mem_wdata.bcast      = (pop_cmd.address & pop_cmd.subnetmask) | ~pop_cmd.subnetmask;
    mem_wdata.netbcast   = (pop_cmd.address & pop_cmd.netmask) | ~pop_cmd.netmask;
  end

  // match of the entry read last cycle
  assign a = cur_r.address;
  always_comb begin
    if (net_locality) begin
      local_m = ((a & rd_entry_r.netmask) == rd_entry_r.net);
    end else begin
      local_m = ((a & rd_entry_r.subnetmask) == rd_entry_r.subnet);
    end
    bcast_m = cur_r.bcast_en && (rd_entry_r.iface == cur_r.iface) &&
              (rd_entry_r.subnetmask != ipv4iac_pkg::ALL_ONES) &&
              ((a == rd_entry_r.bcast) || (a == rd_entry_r.netbcast) ||
               (a == rd_entry_r.subnet) || (a == rd_entry_r.net));
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    scan_idx_nxt    = scan_idx_r;
    chk_idx_nxt     = chk_idx_r;
    chk_vld_nxt     = 1'b0;
    cur_nxt         = cur_r;
    hit_local_nxt   = hit_local_r;
    hit_bcast_nxt   = hit_bcast_r;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt    = out_data_r;
    entry_valid_nxt = entry_valid_r;
    pop_ready       = 1'b0;
    mem_we          = 1'b0;

    // accumulate hits from the table read
    if (chk_vld_r && entry_valid_r[chk_idx_r]) begin
      hit_local_nxt = hit_local_r | local_m;
      hit_bcast_nxt = hit_bcast_r | bcast_m;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.op == ipv4iac_pkg::MODE_CLASSIFY) begin
            pop_ready     = 1'b1;
            cur_nxt       = pop_cmd;
            scan_idx_nxt  = '0;
            hit_local_nxt = 1'b0;
            hit_bcast_nxt = 1'b0;
            state_nxt     = ST_SCAN;
          end else if (out_free) begin
            // program, delete and unused modes answer all zero
            pop_ready     = 1'b1;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (pop_cmd.slot_ok && (pop_cmd.op == ipv4iac_pkg::MODE_PROGRAM)) begin
              mem_we                 = 1'b1;
              entry_valid_nxt[waddr] = 1'b1;
            end else if (pop_cmd.slot_ok && (pop_cmd.op == ipv4iac_pkg::MODE_DELETE)) begin
              entry_valid_nxt[waddr] = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = scan_idx_r;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.is_local     = hit_local_r;
          out_data_nxt.is_broadcast = cur_r.bcast_fixed | hit_bcast_r;
          out_data_nxt.can_forward  = cur_r.can_forward;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      state_r       <= state_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
      entry_valid_r <= entry_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    cur_r       <= cur_nxt;
    hit_local_r <= hit_local_nxt;
    hit_bcast_r <= hit_bcast_nxt;
    out_data_r  <= out_data_nxt;
  end

  // table write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= mem_wdata;
    end
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    rd_entry_r <= mem[scan_idx_r];
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the IPv4 interface address classifier: queued driver, table predictor, scoreboard
module tb;

  localparam int         SLOTS         = ipv4iac_pkg::DEF_ENTRIES;
  localparam int         AW            = ipv4iac_pkg::CFG_ADDR_W;
  localparam int         DW            = ipv4iac_pkg::CFG_DATA_W;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = SLOTS + 8;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  ipv4iac_pkg::in_data_t  in_data     = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  ipv4iac_pkg::out_data_t out_data;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [AW-1:0]          cfg_paddr   = '0;
  logic [DW-1:0]          cfg_pwdata  = '0;
  logic [DW-1:0]          cfg_prdata;
  logic                   cfg_pready;

  ipv4_interface_address_classifier_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus and scoreboard bookkeeping
  ipv4iac_pkg::in_data_t  pending_items[$];
  ipv4iac_pkg::out_data_t expected_flags[$];
  int        items_queued  = 0;
  int        results_seen  = 0;
  int        offered_count = 0;
  int        taken_count   = 0;
  int        mismatches    = 0;
  int        cycle_count   = 0;
  int        in_gap        = 0;
  int        out_gap       = 0;
  bit        steady_flow   = 1'b0;

  // predictor copy of the interface table and the locality register
  logic        local_by_net;
  logic        tbl_valid    [SLOTS];
  logic [3:0]  tbl_iface    [SLOTS];
  logic [31:0] tbl_net      [SLOTS];
  logic [31:0] tbl_netmask  [SLOTS];
  logic [31:0] tbl_subnet   [SLOTS];
  logic [31:0] tbl_submask  [SLOTS];
  logic [31:0] tbl_bcast    [SLOTS];
  logic [31:0] tbl_netbcast [SLOTS];

  // generator's record of what was programmed, to aim classify addresses
  bit          gen_used  [SLOTS];
  logic [31:0] gen_addr  [SLOTS];
  logic [31:0] gen_mask  [SLOTS];
  logic [3:0]  gen_iface [SLOTS];

  function automatic logic [31:0] class_mask_of(input logic [31:0] a);
    if (!a[31]) return ipv4iac_pkg::CLASS_A_MASK;
    if (!a[30]) return ipv4iac_pkg::CLASS_B_MASK;
    return ipv4iac_pkg::CLASS_C_MASK;
  endfunction

  // update the table for program/delete, or answer a classify transaction
  function automatic ipv4iac_pkg::out_data_t apply_and_classify(
      input ipv4iac_pkg::in_data_t item);
    ipv4iac_pkg::out_data_t res;
    logic [31:0] a, nm, sm;
    int          k;
    res = '0;
    a   = item.address;
    k   = item.entry_index;
    case (item.mode)
      ipv4iac_pkg::MODE_PROGRAM: begin
        nm = class_mask_of(a);
        sm = item.subnet_mask;
        if (sm == '0) sm = nm;
        else nm = nm & sm;
        tbl_valid[k]    = 1'b1;
        tbl_iface[k]    = item.interface_id;
        tbl_netmask[k]  = nm;
        tbl_submask[k]  = sm;
        tbl_net[k]      = a & nm;
        tbl_subnet[k]   = a & sm;
        tbl_bcast[k]    = (a & sm) | ~sm;
        tbl_netbcast[k] = (a & nm) | ~nm;
      end
      ipv4iac_pkg::MODE_DELETE: begin
        tbl_valid[k] = 1'b0;
      end
      ipv4iac_pkg::MODE_CLASSIFY: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && (local_by_net ? ((a & tbl_netmask[i]) == tbl_net[i])
                                            : ((a & tbl_submask[i]) == tbl_subnet[i])))
            res.is_local = 1'b1;
        end
        // limited broadcast always qualifies; entry matches need broadcast support
        if (a == ipv4iac_pkg::ALL_ONES || a == '0) begin
          res.is_broadcast = 1'b1;
        end else if (item.iface_broadcast) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_iface[i] == item.interface_id &&
                tbl_submask[i] != ipv4iac_pkg::ALL_ONES &&
                (a == tbl_bcast[i] || a == tbl_netbcast[i] ||
                 a == tbl_subnet[i] || a == tbl_net[i]))
              res.is_broadcast = 1'b1;
          end
        end
        // multicast/experimental, net zero and loopback are never forwarded
        res.can_forward = !(a[31:29] == ipv4iac_pkg::CLASS_DE_TOP ||
                            (!a[31] && (a[31:24] == 8'h00 ||
                                        a[31:24] == ipv4iac_pkg::LOOPBACK_NET[31:24])));
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic ipv4iac_pkg::in_data_t make_item(
      input logic [1:0] mode, input logic [2:0] slot,
      input logic [31:0] addr, input logic [31:0] mask,
      input logic [3:0] ifc, input logic bc);
    ipv4iac_pkg::in_data_t it;
    it.mode            = mode;
    it.entry_index     = slot;
    it.address         = addr;
    it.subnet_mask     = mask;
    it.interface_id    = ifc;
    it.iface_broadcast = bc;
    return it;
  endfunction

  // address drawn across the classes and the reserved ranges
  function automatic logic [31:0] pick_address();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 8))
      0: return {1'b0, r[30:0]};
      1: return {2'b10, r[29:0]};
      2: return {3'b110, r[28:0]};
      3: return {ipv4iac_pkg::CLASS_DE_TOP, r[28:0]};
      4: return {ipv4iac_pkg::LOOPBACK_NET[31:24], r[23:0]};
      5: return {8'h00, r[23:0]};
      6: return ipv4iac_pkg::ALL_ONES;
      7: return '0;
      default: return r;
    endcase
  endfunction

  task automatic push_item(input ipv4iac_pkg::in_data_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // table setups, every class, reserved ranges, host mask, delete, reprogram
  task automatic queue_directed();
    logic [1:0]  prg, del, cls;
    logic [31:0] ones;
    prg  = ipv4iac_pkg::MODE_PROGRAM;
    del  = ipv4iac_pkg::MODE_DELETE;
    cls  = ipv4iac_pkg::MODE_CLASSIFY;
    ones = ipv4iac_pkg::ALL_ONES;
    push_item(make_item(prg, 3'd0, 32'h0a01_0203, 32'h0000_0000, 4'd1, 1'b0));
    push_item(make_item(prg, 3'd1, 32'hac10_0504, 32'hffff_ff00, 4'd2, 1'b0));
    push_item(make_item(prg, 3'd2, 32'hc0a8_0109, ones, 4'd3, 1'b0));
    push_item(make_item(prg, 3'd7, 32'hdfff_fffe, 32'hf0f0_f0f0, 4'd15, 1'b1));
    push_item(make_item(cls, 3'd0, ones, ones, 4'd0, 1'b0));
    push_item(make_item(cls, 3'd7, 32'h0000_0000, 32'h0000_0000, 4'd15, 1'b0));
    push_item(make_item(cls, 3'd0, 32'h0aff_ffff, 32'h0000_0000, 4'd1, 1'b1));
    push_item(make_item(cls, 3'd0, 32'h0aff_ffff, 32'h0000_0000, 4'd1, 1'b0));
    push_item(make_item(cls, 3'd0, 32'h0a00_0000, 32'h0000_0000, 4'd1, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hac10_05ff, 32'h0000_0000, 4'd2, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hac10_ffff, 32'h0000_0000, 4'd2, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hac10_0500, 32'h0000_0000, 4'd2, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hc0a8_01ff, 32'h0000_0000, 4'd3, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hd0f0_f0f0, 32'h0000_0000, 4'd15, 1'b1));
    push_item(make_item(cls, 3'd0, 32'he000_0001, 32'h0000_0000, 4'd0, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hf000_0001, 32'h0000_0000, 4'd0, 1'b1));
    push_item(make_item(cls, 3'd0, 32'h7f00_0001, 32'h0000_0000, 4'd0, 1'b1));
    push_item(make_item(cls, 3'd0, 32'h0001_0203, 32'h0000_0000, 4'd1, 1'b1));
    push_item(make_item(cls, 3'd0, 32'hc800_0001, 32'h0000_0000, 4'd0, 1'b1));
    push_item(make_item(MODE_UNUSED, 3'd5, ones, ones, 4'd15, 1'b1));
    push_item(make_item(del, 3'd0, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b0));
    push_item(make_item(cls, 3'd0, 32'h0a01_0101, 32'h0000_0000, 4'd1, 1'b1));
    push_item(make_item(prg, 3'd1, 32'h8000_0001, 32'h0000_0000, 4'd4, 1'b0));
    push_item(make_item(cls, 3'd0, 32'hac10_05ff, 32'h0000_0000, 4'd2, 1'b1));
    push_item(make_item(cls, 3'd0, 32'h8000_ffff, 32'h0000_0000, 4'd4, 1'b1));
  endtask

  // mostly classify transactions aimed at programmed entries, plus table churn and noise
  task automatic queue_random(input int count);
    ipv4iac_pkg::in_data_t it;
    int          pick, slot, len;
    logic [31:0] base, sm, nm;
    repeat (count) begin
      it.mode            = ipv4iac_pkg::MODE_CLASSIFY;
      it.entry_index     = $urandom_range(0, SLOTS - 1);
      it.address         = $urandom;
      it.subnet_mask     = $urandom;
      it.interface_id    = $urandom_range(0, 15);
      it.iface_broadcast = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        it.mode         = ipv4iac_pkg::MODE_PROGRAM;
        it.address      = pick_address();
        it.interface_id = $urandom_range(0, 3);
        len = $urandom_range(0, 32);
        case ($urandom_range(0, 4))
          0: it.subnet_mask = '0;
          1: it.subnet_mask = ipv4iac_pkg::ALL_ONES;
          2: it.subnet_mask = $urandom;
          default: it.subnet_mask = ipv4iac_pkg::ALL_ONES << (32 - len);
        endcase
        gen_used[it.entry_index]  = 1'b1;
        gen_addr[it.entry_index]  = it.address;
        gen_mask[it.entry_index]  = it.subnet_mask;
        gen_iface[it.entry_index] = it.interface_id;
      end else if (pick < 28) begin
        it.mode = ipv4iac_pkg::MODE_DELETE;
      end else if (pick < 31) begin
        it.mode = MODE_UNUSED;
      end else begin
        slot = $urandom_range(0, SLOTS - 1);
        if (gen_used[slot] && $urandom_range(0, 9) < 7) begin
          base = gen_addr[slot];
          sm   = gen_mask[slot];
          nm   = class_mask_of(base);
          if (sm == '0) sm = nm;
          else nm = nm & sm;
          case ($urandom_range(0, 5))
            0: it.address = base;
            1: it.address = base & sm;
            2: it.address = base & nm;
            3: it.address = (base & sm) | ~sm;
            4: it.address = (base & nm) | ~nm;
            default: it.address = (base & nm) | ($urandom & ~nm);
          endcase
          if ($urandom_range(0, 9) < 8) it.interface_id = gen_iface[slot];
          if ($urandom_range(0, 9) < 8) it.iface_broadcast = 1'b1;
        end else begin
          it.address = pick_address();
        end
      end
      push_item(it);
    end
  endtask

  // APB write of the locality register; upper data bits are don't-care
  task automatic write_local_mode(input logic value);
    logic [31:0] r;
    r = $urandom;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {ipv4iac_pkg::REG_NET_LOCALITY, 2'b00};
    cfg_pwdata  <= {r[31:1], value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // every transaction yields one result, so drained means all results seen
  task automatic wait_drained();
    while (results_seen < items_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver with random idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && taken_count != offered_count)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        offered_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: track config writes, predict accepted transactions, check results
  always @(posedge clk) begin
    ipv4iac_pkg::out_data_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (!rst_n) begin
      local_by_net = ipv4iac_pkg::NET_LOCALITY_RST;
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[AW-1:2] == ipv4iac_pkg::REG_NET_LOCALITY)
        local_by_net = cfg_pwdata[0];
      if (in_valid && in_ready) begin
        expected_flags.push_back(apply_and_classify(in_data));
        taken_count++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_flags.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %b", $time, out_data);
          mismatches++;
        end else begin
          want = expected_flags.pop_front();
          if (out_data.is_local !== want.is_local) begin
            $display("%0t: is_local expected %b actual %b",
                     $time, want.is_local, out_data.is_local);
            mismatches++;
          end
          if (out_data.is_broadcast !== want.is_broadcast) begin
            $display("%0t: is_broadcast expected %b actual %b",
                     $time, want.is_broadcast, out_data.is_broadcast);
            mismatches++;
          end
          if (out_data.can_forward !== want.can_forward) begin
            $display("%0t: can_forward expected %b actual %b",
                     $time, want.can_forward, out_data.can_forward);
            mismatches++;
          end
        end
      end
    end
  end

  // test sequence: reset, directed set, then random phases across both locality modes
  initial begin
    for (int i = 0; i < SLOTS; i++) gen_used[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_drained();

    write_local_mode(1'b0);
    queue_random(300);
    wait_drained();

    write_local_mode(1'b1);
    queue_random(300);
    wait_drained();

    // final stretch runs at full rate on both sides
    write_local_mode(1'b0);
    steady_flow = 1'b1;
    queue_random(350);
    wait_drained();

    if (expected_flags.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_flags.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
